// ===== rtl/core/ccs_pkg.sv =====
// Shared types and character codes for the C comment stripper.
// No dependencies; imported by every module of the block.
package ccs_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [3:0] {
        MODE_CODE  = 4'b0001,
        MODE_STR   = 4'b0010,
        MODE_LINE  = 4'b0100,
        MODE_BLOCK = 4'b1000
    } ccs_mode_t;

    // One or two output bytes caused by one input byte.
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } ccs_pair_t;

endpackage

// ===== rtl/core/ccs_front.sv =====
// Front end: accepts input bytes, tracks the lexer mode and classifies each byte.
// Depends on ccs_pkg; pushes byte pairs into ccs_queue.
module ccs_front
    import ccs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] in_char,
    input  logic       start_of_file,
    input  logic       q_full,
    output logic       q_push,
    output ccs_pair_t  q_data
);

    ccs_mode_t  mode_reg, mode_next;
    logic [7:0] prev_reg, prev_next;
    logic       esc_reg, esc_next;

    ccs_mode_t  m;
    logic [7:0] p;
    logic       e;
    logic [1:0] n_emit;
    logic       acc;

    assign acc = push & ~q_full;

    always_comb
    begin
        m         = start_of_file ? MODE_CODE : mode_reg;
        p         = start_of_file ? 8'h00 : prev_reg;
        e         = start_of_file ? 1'b0 : esc_reg;
        mode_next = m;
        prev_next = in_char;
        esc_next  = e;
        n_emit    = 2'd0;
        q_data.b0 = in_char;
        q_data.b1 = in_char;
        case (m)
            MODE_CODE:
            begin
                if (p == CH_SLASH)
                begin
                    if (in_char == CH_SLASH)
                        mode_next = MODE_LINE;
                    else if (in_char == CH_STAR)
                        mode_next = MODE_BLOCK;
                    else
                    begin
                        // release the held slash with this byte
                        n_emit    = 2'd2;
                        q_data.b0 = p;
                    end
                end
                else if (in_char != CH_SLASH)
                begin
                    n_emit = 2'd1;
                    if (p != CH_BSLASH && p != CH_APOS && in_char == CH_DQUOTE)
                        mode_next = MODE_STR;
                end
            end
            MODE_STR:
            begin
                if (p == CH_BSLASH)
                begin
                    if (!e)
                    begin
                        n_emit    = 2'd2;
                        q_data.b0 = p;
                    end
                    else
                    begin
                        n_emit = 2'd1;
                        if (in_char == CH_DQUOTE)
                            mode_next = MODE_CODE;
                    end
                    esc_next = (in_char == CH_BSLASH);
                end
                else if (in_char != CH_BSLASH)
                begin
                    n_emit = 2'd1;
                    if (in_char == CH_DQUOTE)
                        mode_next = MODE_CODE;
                end
            end
            MODE_LINE:
            begin
                if (p != CH_BSLASH && (in_char inside {CH_LF, CH_CR}))
                begin
                    n_emit    = 2'd1;
                    prev_next = 8'h00;
                    mode_next = MODE_CODE;
                end
            end
            MODE_BLOCK:
            begin
                if (p == CH_STAR && in_char == CH_SLASH)
                begin
                    prev_next = 8'h00;
                    mode_next = MODE_CODE;
                end
            end
            default:
            begin
                mode_next = MODE_CODE;
            end
        endcase
        q_data.two = (n_emit == 2'd2);
    end

    assign q_push = acc & (n_emit != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CODE;
            prev_reg <= 8'h00;
            esc_reg  <= 1'b0;
        end
        else if (acc)
        begin
            mode_reg <= mode_next;
            prev_reg <= prev_next;
            esc_reg  <= esc_next;
        end
    end

endmodule

// ===== rtl/core/ccs_queue.sv =====
// Short queue of byte pairs between front and back end.
// Depends on ccs_pkg for the entry type.
module ccs_queue
    import ccs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  ccs_pair_t wr_data,
    output logic      full,
    input  logic      rd_en,
    output logic      rd_valid,
    output ccs_pair_t rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    ccs_pair_t     mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_en & ~full;
    assign do_rd    = rd_en & rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/ccs_back.sv =====
// Back end: splits queued byte pairs into single bytes in the output register.
// Depends on ccs_pkg for the entry type.
module ccs_back
    import ccs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  ccs_pair_t q_data,
    output logic      q_pop,
    input  logic      pop,
    output logic      empty,
    output logic [7:0] out_char,
    output logic      last_of_run
);

    logic       valid_reg;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       half_reg, half_next;
    logic       load;

    // advance when the output register is free or its byte transfers now
    assign load  = q_valid & (~valid_reg | pop);
    assign empty = ~valid_reg;
    assign out_char    = char_reg;
    assign last_of_run = last_reg;

    always_comb
    begin
        half_next = half_reg;
        q_pop     = 1'b0;
        char_next = q_data.b0;
        last_next = 1'b1;
        if (load)
        begin
            if (q_data.two && !half_reg)
            begin
                last_next = 1'b0;
                half_next = 1'b1;
            end
            else
            begin
                if (half_reg)
                    char_next = q_data.b1;
                half_next = 1'b0;
                q_pop     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            half_reg <= half_next;
            if (load)
                valid_reg <= 1'b1;
            else if (pop)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

endmodule

// ===== rtl/core/c_comment_stripper_unit.sv =====
// Top level of the C comment stripper: front end, pair queue, back end.
// Depends on ccs_pkg, ccs_front, ccs_queue and ccs_back.
//
//   channel   direction  handshake          payload
//   input     in         push / full        in_char, start_of_file
//   result    out        pop / empty        out_char, last_of_run
//
// One input byte is taken per cycle while the pair queue has room; the front
// end classifies it in that cycle. The back end sends one byte per cycle while
// pop is held, so a byte that yields two results leaves as two output bytes;
// the output port sets the sustained rate. Reset clears mode, previous byte,
// escape flag and queue. A stalled result side fills the queue, then raises full.
module c_comment_stripper_unit
    import ccs_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_char,
    input  logic       start_of_file,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic       last_of_run
);

    logic      q_full;
    logic      q_push;
    ccs_pair_t q_wr_data;
    logic      q_valid;
    logic      q_pop;
    ccs_pair_t q_rd_data;

    assign full = q_full;

    ccs_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .in_char       (in_char),
        .start_of_file (start_of_file),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wr_data)
    );

    ccs_queue #(.DEPTH(QDEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data)
    );

    ccs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_rd_data),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .out_char    (out_char),
        .last_of_run (last_of_run)
    );

endmodule
